/* hdl/tria_pkg.sv */
// tilt region and angle indicator: shared types, constants and tables
// used by the cordic/sqrt unit and by the top level
`default_nettype none
package tria_pkg;
  localparam int SampleWidthDef   = 16;
  localparam int AngleFracBitsDef = 6;
  localparam int CordicStepsDef   = 16;
  localparam int TableLen         = 24;
  localparam int ZW               = 24;  // angle accumulator, 2^-16 degree
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 16;

  localparam logic [CfgIdxW-1:0] CFG_X_OFFSET   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_OFFSET   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEAD_BAND  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_NET_READY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LED_ENABLE = 3'd4;

  localparam logic [3:0] RG_FLAT = 4'd0;
  localparam logic [3:0] RG_Q1   = 4'd1;
  localparam logic [3:0] RG_Q2   = 4'd2;
  localparam logic [3:0] RG_Q3   = 4'd3;
  localparam logic [3:0] RG_Q4   = 4'd4;
  localparam logic [3:0] RG_YN   = 4'd5;
  localparam logic [3:0] RG_YP   = 4'd6;
  localparam logic [3:0] RG_XP   = 4'd7;
  localparam logic [3:0] RG_XN   = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic do_angle;
  } calc_ctl_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0:  r = 24'd2949120;
      5'd1:  r = 24'd1740967;
      5'd2:  r = 24'd919879;
      5'd3:  r = 24'd466945;
      5'd4:  r = 24'd234379;
      5'd5:  r = 24'd117304;
      5'd6:  r = 24'd58666;
      5'd7:  r = 24'd29335;
      5'd8:  r = 24'd14668;
      5'd9:  r = 24'd7334;
      5'd10: r = 24'd3667;
      5'd11: r = 24'd1833;
      5'd12: r = 24'd917;
      5'd13: r = 24'd458;
      5'd14: r = 24'd229;
      5'd15: r = 24'd115;
      5'd16: r = 24'd57;
      5'd17: r = 24'd29;
      5'd18: r = 24'd14;
      5'd19: r = 24'd7;
      5'd20: r = 24'd4;
      5'd21: r = 24'd2;
      5'd22: r = 24'd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* hdl/tria_calc.sv */
// tilt region and angle indicator: iterative cordic angle and
// bit-pair square root; depends on tria_pkg
`default_nettype none
module tria_calc import tria_pkg::*; #(
  parameter int SampleWidth   = SampleWidthDef,
  parameter int AngleFracBits = AngleFracBitsDef,
  parameter int CordicSteps   = CordicStepsDef,
  localparam int AW = SampleWidth + 1,
  localparam int CW = AW + 26,
  localparam int SW = 2 * AW,
  localparam int RW = AW,
  localparam int AngW = 7 + AngleFracBits
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire calc_ctl_t       ctl_i,
  input  wire logic [AW-1:0]   ax_i,
  input  wire logic [AW-1:0]   ay_i,
  input  wire logic [SW-1:0]   sum_i,
  output logic                 done_o,
  output logic [AngW-1:0]      angle_o,
  output logic [RW-1:0]        root_o
);
  localparam int Steps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int SqIter = RW;
  localparam int Cnt = (Steps > SqIter) ? Steps : SqIter;
  localparam int CntW = $clog2(Cnt + 1);
  localparam int RoundShift = 16 - AngleFracBits;
  localparam int ZS = ZW + 2;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZS-1:0] z_q, z_d;
  logic [SW-1:0] rem_q, rem_d, src_q, src_d;
  logic [RW-1:0] res_q, res_d;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZS-1:0] zc, zt;
  logic [SW+1:0] trial;
  logic [4:0] ti;

  assign ti = 5'(cnt_q);

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    rem_d = rem_q; src_d = src_q; res_d = res_q;
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    zt = ZS'(atan_entry(ti));
    trial = {2'b00, rem_q[SW-3:0], src_q[SW-1:SW-2]} - {2'b00, res_q, 2'b01};
    if (ctl_i.start) begin
      busy_d = 1'b1; cnt_d = '0;
      x_d = CW'({ay_i, 24'd0}); y_d = CW'({ax_i, 24'd0}); z_d = '0;
      rem_d = '0; src_d = sum_i; res_d = '0;
    end else if (busy_q) begin
      if (32'(cnt_q) < Steps) begin
        if (!y_q[CW-1]) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + zt;
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - zt;
        end
      end
      if (32'(cnt_q) < SqIter) begin
        // one result bit per cycle from the top two bits of the sum
        src_d = {src_q[SW-3:0], 2'b00};
        if (!trial[SW+1]) begin
          rem_d = SW'(trial); res_d = {res_q[RW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[SW-3:0], src_q[SW-1:SW-2]}; res_d = {res_q[RW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (32'(cnt_q) == Cnt - 1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    rem_q <= rem_d; src_q <= src_d; res_q <= res_d;
  end

  always_comb begin
    zc = z_q;
    if (z_q < 0) zc = '0;
    if (z_q > ZS'(90 * 65536)) zc = ZS'(90 * 65536);
    angle_o = AngW'((zc + ZS'((1 << RoundShift) >> 1)) >>> RoundShift);
  end
  assign root_o = res_q;
  assign done_o = busy_q && (32'(cnt_q) == Cnt - 1);

  logic unused_ok;
  assign unused_ok = ctl_i.do_angle;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("calc done without finishing");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q && cnt_q == '0) else $error("calc start lost");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> 32'(cnt_q) < Cnt) else $error("calc counter overrun");
endmodule
`default_nettype wire

/* hdl/tilt_region_angle_indicator.sv */
// tilt region and angle indicator top level: offsets, region decision,
// heading and led pattern; depends on tria_pkg and tria_calc
`default_nettype none
// One sample pair per request. After a request is taken the squares of the
// offset-corrected samples are built by shift-add, one multiplier bit a cycle,
// first for x and then for y. Then the angle (cordic, one step a cycle) and
// the magnitude (square root, one result bit a cycle) run side by side in
// tria_calc. The next request is taken once the result has left.
module tilt_region_angle_indicator import tria_pkg::*; #(
  parameter int SAMPLE_WIDTH    = SampleWidthDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef,
  parameter int CORDIC_STEPS    = CordicStepsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [15:0]   x_sample_i,
  input  wire logic signed [15:0]   y_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [3:0]                region_o,
  output logic [14:0]               heading_o,
  output logic [15:0]               magnitude_o,
  output logic [11:0]               led_pattern_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);
  localparam int AW = SAMPLE_WIDTH + 1;
  localparam int DW = 18;
  localparam int AngW = 7 + ANGLE_FRAC_BITS;
  localparam int SqCntW = $clog2(AW);

  state_e state_q, state_d;
  logic signed [15:0] xoff_q, yoff_q;
  logic [9:0] band_q;
  logic net_q, len_q;
  logic [3:0] hreg_q, hreg_d;
  logic [AngW-1:0] hang_q;
  logic do_ang_q;
  logic [AW-1:0] ax_q, ay_q, adx, ady;
  logic [2*AW-1:0] sum_q;
  logic sq_busy_q, sq_q, sq_last, sum_go_q;
  logic [SqCntW-1:0] sq_cnt_q;
  logic [AW-1:0] sq_mul_q;
  logic [2*AW-1:0] sq_mcd_q;
  logic [2*AW:0] sq_acc_q, sq_acc_d;

  logic signed [DW-1:0] dx, dy, hb;
  logic xn, xp, xz, yn, yp, yz;
  calc_ctl_t ctl;
  logic done;
  logic [AngW-1:0] ang_c;
  logic [AW-1:0] root;

  // sample fields reduced to SAMPLE_WIDTH and sign extended
  assign dx = DW'(signed'(x_sample_i[SAMPLE_WIDTH-1:0])) - DW'(xoff_q);
  assign dy = DW'(signed'(y_sample_i[SAMPLE_WIDTH-1:0])) - DW'(yoff_q);
  assign hb = DW'(signed'({1'b0, band_q}));
  always_comb begin
    xn = dx < -hb; xp = dx > hb; xz = (dx > -hb) && (dx < hb);
    yn = dy < -hb; yp = dy > hb; yz = (dy > -hb) && (dy < hb);
    hreg_d = hreg_q;
    if (xz && yz) hreg_d = RG_FLAT;
    else if (yn && xz) hreg_d = RG_YN;
    else if (yp && xz) hreg_d = RG_YP;
    else if (xp && yz) hreg_d = RG_XP;
    else if (xn && yz) hreg_d = RG_XN;
    else if (xp && yp) hreg_d = RG_Q3;
    else if (xp && yn) hreg_d = RG_Q4;
    else if (xn && yp) hreg_d = RG_Q2;
    else if (xn && yn) hreg_d = RG_Q1;
  end

  assign adx = dx[DW-1] ? AW'(-dx) : AW'(dx);
  assign ady = dy[DW-1] ? AW'(-dy) : AW'(dy);

  // squares by shift-add, one multiplier bit per cycle: |dx| first, then |dy|
  assign sq_last = (32'(sq_cnt_q) == AW - 1);
  assign sq_acc_d = sq_mul_q[0] ? sq_acc_q + (2*AW+1)'(sq_mcd_q) : sq_acc_q;

  always_comb begin
    state_d = state_q;
    ctl = '0;
    ctl.start = sum_go_q;
    ctl.do_angle = do_ang_q;
    in_ready_o = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_WORK;
      ST_WORK: if (done) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      xoff_q <= '0; yoff_q <= '0; band_q <= 10'd10; net_q <= 1'b0; len_q <= 1'b1;
      hreg_q <= RG_Q1; hang_q <= '0; do_ang_q <= 1'b0;
      sq_busy_q <= 1'b0; sq_q <= 1'b0; sq_cnt_q <= '0; sum_go_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_go_q <= sq_busy_q && sq_q && sq_last;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_OFFSET:   xoff_q <= cfg_data_i;
          CFG_Y_OFFSET:   yoff_q <= cfg_data_i;
          CFG_DEAD_BAND:  band_q <= cfg_data_i[9:0];
          CFG_NET_READY:  net_q <= cfg_data_i[0];
          CFG_LED_ENABLE: len_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        hreg_q <= hreg_d;
        do_ang_q <= (dx != 0) && (dy != 0);
        sq_busy_q <= 1'b1; sq_q <= 1'b0; sq_cnt_q <= '0;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_last ? '0 : sq_cnt_q + 1'b1;
        if (sq_last) sq_q <= 1'b1;
        if (sq_last && sq_q) sq_busy_q <= 1'b0;
      end
      if (done && do_ang_q) hang_q <= ang_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ax_q <= adx;
      ay_q <= ady;
      sq_mul_q <= adx; sq_mcd_q <= (2*AW)'(adx); sq_acc_q <= '0;
    end else if (sq_busy_q) begin
      sq_acc_q <= sq_acc_d;
      if (sq_last && !sq_q) begin
        sq_mul_q <= ay_q; sq_mcd_q <= (2*AW)'(ay_q);
      end else begin
        sq_mul_q <= sq_mul_q >> 1; sq_mcd_q <= sq_mcd_q << 1;
      end
      // (dx^2+dy^2)/2 once the last bit of |dy| is in
      if (sq_last && sq_q) sum_q <= (2*AW)'(sq_acc_d >> 1);
    end
  end

  tria_calc #(
    .SampleWidth(SAMPLE_WIDTH), .AngleFracBits(ANGLE_FRAC_BITS),
    .CordicSteps(CORDIC_STEPS)
  ) u_calc (
    .clk_i, .rst_ni,
    .ctl_i(ctl),
    .ax_i(ax_q), .ay_i(ay_q), .sum_i(sum_q),
    .done_o(done), .angle_o(ang_c), .root_o(root)
  );

  // output decode from the held region and angle
  logic [AngW-1:0] a;
  logic [1:0] sec;
  logic [14:0] hd;
  logic [11:0] ld;
  always_comb begin
    a = hang_q;
    sec = (a < AngW'(30 << ANGLE_FRAC_BITS)) ? 2'd0 :
          (a < AngW'(60 << ANGLE_FRAC_BITS)) ? 2'd1 : 2'd2;
    case (hreg_q)
      RG_FLAT: begin hd = '0; ld = net_q ? 12'hFFF : 12'h555; end
      RG_Q1: begin hd = 15'(a); ld = 12'(1 << sec); end
      RG_Q2: begin hd = 15'((180 << ANGLE_FRAC_BITS) - 32'(a)); ld = 12'(1 << (5 - sec)); end
      RG_Q3: begin hd = 15'((180 << ANGLE_FRAC_BITS) + 32'(a)); ld = 12'(1 << (6 + sec)); end
      RG_Q4: begin hd = 15'((360 << ANGLE_FRAC_BITS) - 32'(a)); ld = 12'(1 << (11 - sec)); end
      RG_YN: begin hd = '0; ld = 12'd1; end
      RG_YP: begin hd = 15'(180 << ANGLE_FRAC_BITS); ld = 12'd1 << 6; end
      RG_XP: begin hd = 15'(270 << ANGLE_FRAC_BITS); ld = 12'd1 << 9; end
      default: begin hd = 15'(90 << ANGLE_FRAC_BITS); ld = 12'd1 << 3; end
    endcase
    if (!len_q) ld = '0;
  end

  assign region_o = hreg_q;
  assign heading_o = hd;
  assign led_pattern_o = ld;
  assign magnitude_o = 16'(root);

  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(done)) else $error("result without calc");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken while result held");
  a_hold_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(region_o)) else $error("region moved");
endmodule
`default_nettype wire
